@@ sv/bddp_pkg.sv @@
`timescale 1ns / 1ps

package bddp_pkg;

  // Radix mode codes
  localparam logic RADIX_BIN = 1'b0;   // base 65536 digits
  localparam logic RADIX_DEC = 1'b1;   // base 10000 digits

  // Register index (word address) of the radix mode register
  localparam logic REG_RADIX = 1'b0;

  localparam int unsigned DIGIT_W = 16;
  localparam int unsigned ACC_W   = 32;
  localparam int unsigned CNT_W   = 16;

  // Decimal mode constants
  localparam logic [ACC_W-1:0]   ACC_BASE       = 32'd3000000000;
  localparam logic [DIGIT_W-1:0] DEC_MAX        = 16'd9999;
  localparam logic [13:0]        DEC_DIGIT      = 14'd10000;
  localparam logic [4:0]         BASE_PER_COUNT = 5'd30;

  // x / 10000 == (x * RECIP_1E4) >> RECIP_SHIFT for every 32-bit x
  localparam logic [31:0] RECIP_1E4   = 32'd3518437209;
  localparam int unsigned RECIP_SHIFT = 45;
  localparam int unsigned Q1_W        = 19;   // acc / 1e4 fits 19 bits
  localparam int unsigned Q2_W        = 6;    // acc / 1e8 fits 6 bits
  localparam int unsigned HI_W        = 22;   // acc / 1e8 + 30 * count

  // Queue between front and back
  localparam int unsigned QDEPTH = 4;
  localparam int unsigned QPW    = $clog2(QDEPTH);

  typedef struct packed {
    logic [DIGIT_W-1:0] x;
    logic [DIGIT_W-1:0] y;
    logic               last;
    logic               mode;
  } item_t;

  typedef struct packed {
    logic             empty;
    logic             full;
  } q_stat_t;

  typedef struct packed {
    logic [ACC_W-1:0] acc;
    logic [CNT_W-1:0] cnt;
    logic             mode;
  } fin_t;

endpackage

@@ sv/bddp_front.sv @@
`timescale 1ns / 1ps

module bddp_front
  import bddp_pkg::*;
(
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [DIGIT_W-1:0] in_x_digit,
  input  logic [DIGIT_W-1:0] in_y_digit,
  input  logic               in_last_term,
  input  logic               radix_mode,
  input  q_stat_t            q_stat,
  output logic               push,
  output item_t              push_item
);

  // Stall only on a full queue; it never looks at in_valid
  assign in_stall = q_stat.full;
  assign push     = in_valid & ~q_stat.full;

  // Clamp decimal digits before they reach the multiplier
  always_comb begin
    push_item.x    = in_x_digit;
    push_item.y    = in_y_digit;
    push_item.last = in_last_term;
    push_item.mode = radix_mode;
    if (radix_mode == RADIX_DEC) begin
      if (in_x_digit > DEC_MAX) begin
        push_item.x = DEC_MAX;
      end
      if (in_y_digit > DEC_MAX) begin
        push_item.y = DEC_MAX;
      end
    end
  end

endmodule

@@ sv/bddp_queue.sv @@
`timescale 1ns / 1ps

module bddp_queue
  import bddp_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  item_t   push_item,
  input  logic    pop,
  output item_t   pop_item,
  output q_stat_t q_stat
);

  item_t          qmem [QDEPTH];
  logic [QPW-1:0] wr_ptr_r;
  logic [QPW-1:0] wr_ptr_nxt;
  logic [QPW-1:0] rd_ptr_r;
  logic [QPW-1:0] rd_ptr_nxt;
  logic [QPW:0]   count_r;
  logic [QPW:0]   count_nxt;
  logic           do_pop;

  assign q_stat.empty = (count_r == '0);
  assign q_stat.full  = (count_r == (QPW+1)'(QDEPTH));
  assign do_pop       = pop & ~q_stat.empty;
  assign pop_item     = qmem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = rd_ptr_r + 1'b1;
    end
    if (push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (!push && do_pop) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      qmem[wr_ptr_r] <= push_item;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= (QPW+1)'(QDEPTH))
    else $error("queue count above depth");

  a_count_up: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !do_pop) |=> (count_r == $past(count_r) + 1'b1))
    else $error("queue count did not advance on push");

endmodule

@@ sv/bddp_back.sv @@
`timescale 1ns / 1ps

module bddp_back
  import bddp_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    adv,
  input  q_stat_t q_stat,
  input  item_t   pop_item,
  output logic    pop,
  output logic    fin_valid,
  output fin_t    fin
);

  // Multiply stage
  logic             m_valid_r;
  logic [ACC_W-1:0] m_prod_r;
  logic             m_last_r;
  logic             m_mode_r;

  // Running column state
  logic [ACC_W-1:0] acc_r;
  logic [ACC_W-1:0] acc_nxt;
  logic [CNT_W-1:0] cnt_r;
  logic [CNT_W-1:0] cnt_nxt;

  // Finished sum, handed to the digit converter
  logic             fin_valid_r;
  fin_t             fin_r;
  fin_t             fin_nxt;

  logic [ACC_W:0]   sum_bin;
  logic [ACC_W-1:0] sum_dec;
  logic [ACC_W-1:0] sum_red;

  assign pop = adv & ~q_stat.empty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      m_valid_r <= 1'b0;
    end else if (adv) begin
      m_valid_r <= ~q_stat.empty;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      m_prod_r <= ACC_W'(pop_item.x) * ACC_W'(pop_item.y);
      m_last_r <= pop_item.last;
      m_mode_r <= pop_item.mode;
    end
  end

  // Add the product; count wraps in binary mode, reduce by 3e9 in decimal mode
  always_comb begin
    sum_bin = {1'b0, acc_r} + {1'b0, m_prod_r};
    sum_dec = acc_r + m_prod_r;
    sum_red = sum_dec - ACC_BASE;
    fin_nxt.mode = m_mode_r;
    if (m_mode_r == RADIX_DEC) begin
      if (sum_dec >= ACC_BASE) begin
        fin_nxt.acc = sum_red;
        fin_nxt.cnt = cnt_r + 1'b1;
      end else begin
        fin_nxt.acc = sum_dec;
        fin_nxt.cnt = cnt_r;
      end
    end else begin
      fin_nxt.acc = sum_bin[ACC_W-1:0];
      fin_nxt.cnt = cnt_r + CNT_W'(sum_bin[ACC_W]);
    end
    // Clear the column after its last pair
    if (m_last_r) begin
      acc_nxt = '0;
      cnt_nxt = '0;
    end else begin
      acc_nxt = fin_nxt.acc;
      cnt_nxt = fin_nxt.cnt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r       <= '0;
      cnt_r       <= '0;
      fin_valid_r <= 1'b0;
    end else if (adv) begin
      if (m_valid_r) begin
        acc_r <= acc_nxt;
        cnt_r <= cnt_nxt;
      end
      fin_valid_r <= m_valid_r & m_last_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      fin_r <= fin_nxt;
    end
  end

  assign fin_valid = fin_valid_r;
  assign fin       = fin_r;

  a_clear_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && m_valid_r && m_last_r) |=> (acc_r == '0 && cnt_r == '0))
    else $error("column state not cleared after last pair");

endmodule

@@ sv/bddp_conv.sv @@
`timescale 1ns / 1ps

module bddp_conv
  import bddp_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               fin_valid,
  input  fin_t               fin,
  output logic               adv,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [DIGIT_W-1:0] out_low_digit,
  output logic [DIGIT_W-1:0] out_mid_digit,
  output logic [DIGIT_W-1:0] out_high_digit
);

  // Stage P: reciprocal multiply for acc / 1e4
  logic             p_valid_r;
  fin_t             p_fin_r;
  logic [63:0]      p_prod_r;
  logic [20:0]      p_cnt30_r;

  // Stage Q: low digit and reciprocal multiply for acc / 1e8
  logic             q_valid_r;
  fin_t             q_fin_r;
  logic [Q1_W-1:0]  q_q1_r;
  logic [DIGIT_W-1:0] q_low_r;
  logic [50:0]      q_prod_r;
  logic [20:0]      q_cnt30_r;

  // Output register
  logic               o_valid_r;
  logic               o_mode_r;
  logic [DIGIT_W-1:0] o_low_r;
  logic [DIGIT_W-1:0] o_mid_r;
  logic [DIGIT_W-1:0] o_high_r;
  logic [DIGIT_W-1:0] o_low_nxt;
  logic [DIGIT_W-1:0] o_mid_nxt;
  logic [DIGIT_W-1:0] o_high_nxt;

  logic [Q1_W-1:0]  q1;
  logic [ACC_W-1:0] low_full;
  logic [Q2_W-1:0]  q2;
  logic [Q1_W-1:0]  mid_full;
  logic [HI_W-1:0]  hi_full;

  assign adv = ~o_valid_r | ~out_stall;

  assign q1       = p_prod_r[RECIP_SHIFT +: Q1_W];
  assign low_full = p_fin_r.acc - ACC_W'(ACC_W'(q1) * ACC_W'(DEC_DIGIT));
  assign q2       = q_prod_r[RECIP_SHIFT +: Q2_W];
  assign mid_full = q_q1_r - Q1_W'(Q1_W'(q2) * Q1_W'(DEC_DIGIT));
  assign hi_full  = HI_W'(q2) + HI_W'(q_cnt30_r);

  always_comb begin
    if (q_fin_r.mode == RADIX_DEC) begin
      o_low_nxt = q_low_r;
      o_mid_nxt = DIGIT_W'(mid_full);
      if (hi_full > HI_W'(DEC_MAX)) begin
        o_high_nxt = DEC_MAX;
      end else begin
        o_high_nxt = DIGIT_W'(hi_full);
      end
    end else begin
      o_low_nxt  = q_fin_r.acc[DIGIT_W-1:0];
      o_mid_nxt  = q_fin_r.acc[ACC_W-1:DIGIT_W];
      o_high_nxt = q_fin_r.cnt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      p_valid_r <= 1'b0;
      q_valid_r <= 1'b0;
      o_valid_r <= 1'b0;
    end else if (adv) begin
      p_valid_r <= fin_valid;
      q_valid_r <= p_valid_r;
      o_valid_r <= q_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      p_fin_r   <= fin;
      p_prod_r  <= 64'(fin.acc) * 64'(RECIP_1E4);
      p_cnt30_r <= 21'(fin.cnt) * 21'(BASE_PER_COUNT);
      q_fin_r   <= p_fin_r;
      q_q1_r    <= q1;
      q_low_r   <= low_full[DIGIT_W-1:0];
      q_prod_r  <= 51'(q1) * 51'(RECIP_1E4);
      q_cnt30_r <= p_cnt30_r;
      o_mode_r  <= q_fin_r.mode;
      o_low_r   <= o_low_nxt;
      o_mid_r   <= o_mid_nxt;
      o_high_r  <= o_high_nxt;
    end
  end

  assign out_valid      = o_valid_r;
  assign out_low_digit  = o_low_r;
  assign out_mid_digit  = o_mid_r;
  assign out_high_digit = o_high_r;

  a_dec_digits: assert property (@(posedge clk) disable iff (!rst_n)
    (o_valid_r && o_mode_r == RADIX_DEC) |->
      (o_low_r <= DEC_MAX && o_mid_r <= DEC_MAX && o_high_r <= DEC_MAX))
    else $error("decimal digit out of range");

endmodule

@@ sv/bignum_digit_dot_product.sv @@
`timescale 1ns / 1ps

// Digit dot-product column accumulator for multiprecision multiply. Feed one
// digit pair per item (x[i] with y[n-1-i]) and mark the final pair with
// in_last_term; one result of three 16-bit digits follows each final pair and
// the column state clears for the next sum. The block takes one item every
// cycle while out_stall is low: the 32-bit accumulate (add, compare against
// 3e9, subtract) is combinational ahead of the column registers, so pairs of
// the same column stream without gaps. After its final pair is accepted, a
// result passes through the queue, the 16x16 multiply, the accumulate, two
// reciprocal-multiply stages for the base-10000 split and the output
// register. A four-entry queue sits between the input side and the
// arithmetic pipeline; when out_stall holds the output, the pipeline
// freezes, the queue fills and in_stall rises. radix_mode (address 0) picks
// base 65536 (0) or base 10000 (1); write it only while the block is idle.

module bignum_digit_dot_product
  import bddp_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  // Configuration port
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  // Input items
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [DIGIT_W-1:0] in_x_digit,
  input  logic [DIGIT_W-1:0] in_y_digit,
  input  logic               in_last_term,
  // Result items
  output logic               out_valid,
  input  logic               out_stall,
  output logic [DIGIT_W-1:0] out_low_digit,
  output logic [DIGIT_W-1:0] out_mid_digit,
  output logic [DIGIT_W-1:0] out_high_digit
);

  logic    radix_r;
  logic    radix_nxt;
  logic    cfg_wr;

  q_stat_t q_stat;
  logic    push;
  item_t   push_item;
  logic    pop;
  item_t   pop_item;
  logic    adv;
  logic    fin_valid;
  fin_t    fin;

  // Register file: only radix_mode lives here; paddr[2] is the word index
  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_comb begin
    radix_nxt = radix_r;
    if (cfg_wr && paddr[2] == REG_RADIX) begin
      radix_nxt = pwdata[0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radix_r <= RADIX_BIN;
    end else begin
      radix_r <= radix_nxt;
    end
  end

  // Read back the mode; unmapped words read as zero
  assign prdata = (paddr[2] == REG_RADIX) ? {31'b0, radix_r} : 32'b0;

  // Front: accept items, clamp decimal digits, tag with the mode
  bddp_front u_front (
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_x_digit   (in_x_digit),
    .in_y_digit   (in_y_digit),
    .in_last_term (in_last_term),
    .radix_mode   (radix_r),
    .q_stat       (q_stat),
    .push         (push),
    .push_item    (push_item)
  );

  // Decouple the input side from the arithmetic pipeline
  bddp_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .pop_item  (pop_item),
    .q_stat    (q_stat)
  );

  // Back: multiply and accumulate the column
  bddp_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .adv       (adv),
    .q_stat    (q_stat),
    .pop_item  (pop_item),
    .pop       (pop),
    .fin_valid (fin_valid),
    .fin       (fin)
  );

  // Split the finished sum into three digits and hold the result
  bddp_conv u_conv (
    .clk            (clk),
    .rst_n          (rst_n),
    .fin_valid      (fin_valid),
    .fin            (fin),
    .adv            (adv),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_low_digit  (out_low_digit),
    .out_mid_digit  (out_mid_digit),
    .out_high_digit (out_high_digit)
  );

endmodule

@@ dv/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
  import bddp_pkg::*;

  // Run limits and pacing
  localparam int unsigned CYCLE_LIMIT   = 2_000_000;
  localparam int unsigned RANDOM_ITEMS  = 350;
  localparam int unsigned CALM_ITEMS    = 100;  // final stretch with no idling
  localparam int unsigned SETTLE_CYCLES = 30;   // stall burst + queue + pipeline
  localparam int unsigned HOLD_CYCLES   = 80;   // long output hold to fill the queue

  localparam logic [31:0] DEC_PAIR   = 32'd100000000;
  localparam logic [2:0]  RADIX_ADDR = {REG_RADIX, 2'b00};

  typedef struct packed {
    logic [DIGIT_W-1:0] low;
    logic [DIGIT_W-1:0] mid;
    logic [DIGIT_W-1:0] high;
  } digits_t;

  // One row of the directed plan: the pair is sent reps times, last_term only
  // on the final copy. Where typed is set the result is the one written here.
  typedef struct packed {
    logic               mode;
    logic [DIGIT_W-1:0] x;
    logic [DIGIT_W-1:0] y;
    logic               last;
    logic [16:0]        reps;
    logic               typed;
    digits_t            want;
  } plan_row_t;

  localparam digits_t NO_WANT = '0;

  localparam plan_row_t DIRECTED [0:23] = '{
    // base 65536: zero after reset, extremes, single-bit product
    '{RADIX_BIN, 16'h0000, 16'h0000, 1'b1, 17'd1, 1'b1, '{16'h0000, 16'h0000, 16'h0000}},
    '{RADIX_BIN, 16'hffff, 16'hffff, 1'b1, 17'd1, 1'b1, '{16'h0001, 16'hfffe, 16'h0000}},
    '{RADIX_BIN, 16'hffff, 16'h0000, 1'b1, 17'd1, 1'b1, '{16'h0000, 16'h0000, 16'h0000}},
    '{RADIX_BIN, 16'h0000, 16'hffff, 1'b1, 17'd1, 1'b1, '{16'h0000, 16'h0000, 16'h0000}},
    '{RADIX_BIN, 16'h0001, 16'h0001, 1'b1, 17'd1, 1'b1, '{16'h0001, 16'h0000, 16'h0000}},
    // two max products wrap the accumulator once
    '{RADIX_BIN, 16'hffff, 16'hffff, 1'b0, 17'd1, 1'b0, NO_WANT},
    '{RADIX_BIN, 16'hffff, 16'hffff, 1'b1, 17'd1, 1'b0, NO_WANT},
    // alternating bit patterns
    '{RADIX_BIN, 16'haaaa, 16'h5555, 1'b0, 17'd3, 1'b0, NO_WANT},
    '{RADIX_BIN, 16'h5555, 16'haaaa, 1'b1, 17'd1, 1'b0, NO_WANT},
    // build a large count, then finish the sum in base 10000: high digit clamps
    '{RADIX_BIN, 16'hffff, 16'hffff, 1'b0, 17'd340, 1'b0, NO_WANT},
    '{RADIX_DEC, 16'h0000, 16'h0000, 1'b1, 17'd1, 1'b0, NO_WANT},
    // base 10000: zero, max digit, digits above 9999 clamped
    '{RADIX_DEC, 16'd0, 16'd0, 1'b1, 17'd1, 1'b1, '{16'd0, 16'd0, 16'd0}},
    '{RADIX_DEC, 16'd9999, 16'd9999, 1'b1, 17'd1, 1'b1, '{16'd1, 16'd9998, 16'd0}},
    '{RADIX_DEC, 16'hffff, 16'hffff, 1'b1, 17'd1, 1'b1, '{16'd1, 16'd9998, 16'd0}},
    '{RADIX_DEC, 16'd10000, 16'd1, 1'b1, 17'd1, 1'b1, '{16'd9999, 16'd0, 16'd0}},
    // enough max pairs to cross 3e9 and count a reduction
    '{RADIX_DEC, 16'd9999, 16'd9999, 1'b0, 17'd31, 1'b0, NO_WANT},
    '{RADIX_DEC, 16'd9999, 16'd9999, 1'b1, 17'd1, 1'b0, NO_WANT},
    '{RADIX_DEC, 16'd1, 16'd10000, 1'b1, 17'd1, 1'b1, '{16'd9999, 16'd0, 16'd0}},
    // switch radix in the middle of a sum, both directions
    '{RADIX_DEC, 16'd9999, 16'd9999, 1'b0, 17'd5, 1'b0, NO_WANT},
    '{RADIX_BIN, 16'hffff, 16'hffff, 1'b1, 17'd1, 1'b0, NO_WANT},
    '{RADIX_BIN, 16'hffff, 16'hc000, 1'b0, 17'd1, 1'b0, NO_WANT},
    '{RADIX_DEC, 16'd1, 16'd1, 1'b1, 17'd1, 1'b0, NO_WANT},
    // carry a near-full accumulator into base 10000 so the add wraps
    '{RADIX_BIN, 16'hffff, 16'hffff, 1'b0, 17'd1, 1'b0, NO_WANT},
    '{RADIX_DEC, 16'd9999, 16'd9999, 1'b1, 17'd1, 1'b0, NO_WANT}
  };

  // Block ports; every input starts at a known value
  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [2:0]         paddr = '0;
  logic [31:0]        pwdata = '0;
  logic [31:0]        prdata;
  logic               pready;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [DIGIT_W-1:0] in_x_digit = '0;
  logic [DIGIT_W-1:0] in_y_digit = '0;
  logic               in_last_term = 1'b0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [DIGIT_W-1:0] out_low_digit;
  logic [DIGIT_W-1:0] out_mid_digit;
  logic [DIGIT_W-1:0] out_high_digit;

  // Shadow of the column state and the radix register
  logic [ACC_W-1:0] col_acc = '0;
  logic [CNT_W-1:0] col_ovf = '0;
  logic             radix_q = RADIX_BIN;

  // Column sums still owed by the block, oldest first
  digits_t column_sums[$];
  digits_t seen_want;

  // Pacing knobs for the sender and the receiver
  int unsigned gap_pct   = 15;
  int unsigned stall_pct = 20;
  bit          calm      = 1'b0;
  bit          settle    = 1'b0;
  bit          hold_req  = 1'b0;

  int unsigned failures = 0;
  int unsigned cycles   = 0;

  bignum_digit_dot_product dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_x_digit     (in_x_digit),
    .in_y_digit     (in_y_digit),
    .in_last_term   (in_last_term),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_low_digit  (out_low_digit),
    .out_mid_digit  (out_mid_digit),
    .out_high_digit (out_high_digit)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Fold one digit pair into the shadow column; on the final pair form the
  // three output digits and clear the column.
  function automatic void fold_pair(input logic [DIGIT_W-1:0] xd_in,
                                    input logic [DIGIT_W-1:0] yd_in,
                                    input logic last, output logic emits,
                                    output digits_t res);
    logic [DIGIT_W-1:0] xd;
    logic [DIGIT_W-1:0] yd;
    logic [ACC_W-1:0]   sum;
    logic [31:0]        hi;
    xd = xd_in;
    yd = yd_in;
    res = '0;
    emits = last;
    if (radix_q == RADIX_DEC) begin
      // clamp digits, then reduce by 3e9 at most once per pair
      if (xd > DEC_MAX) xd = DEC_MAX;
      if (yd > DEC_MAX) yd = DEC_MAX;
      sum = col_acc + 32'(xd) * 32'(yd);
      if (sum >= ACC_BASE) begin
        col_ovf = col_ovf + 1'b1;
        sum = sum - ACC_BASE;
      end
    end else begin
      // count every wrap past 2^32
      sum = col_acc + 32'(xd) * 32'(yd);
      if (sum < col_acc) col_ovf = col_ovf + 1'b1;
    end
    col_acc = sum;
    if (last) begin
      if (radix_q == RADIX_DEC) begin
        hi = col_acc / DEC_PAIR + 32'(BASE_PER_COUNT) * 32'(col_ovf);
        if (hi > 32'(DEC_MAX)) hi = 32'(DEC_MAX);
        res.low  = 16'(col_acc % 32'(DEC_DIGIT));
        res.mid  = 16'((col_acc / 32'(DEC_DIGIT)) % 32'(DEC_DIGIT));
        res.high = 16'(hi);
      end else begin
        res.low  = col_acc[15:0];
        res.mid  = col_acc[31:16];
        res.high = col_ovf;
      end
      col_acc = '0;
      col_ovf = '0;
    end
  endfunction

  // Heavy digits drive long sums toward wraps and 3e9 reductions
  function automatic logic [DIGIT_W-1:0] pick_digit(input bit heavy);
    case (heavy ? $urandom_range(0, 1) : $urandom_range(0, 3))
      0: return 16'hffff;
      1: return 16'($urandom_range(9990, 10010));
      2: return 16'($urandom);
      default: return 16'($urandom_range(0, 15));
    endcase
  endfunction

  // Offer one item, maybe after an idle burst; enter and leave at a falling
  // edge. Predict at the accepting edge.
  task automatic send_pair(input logic [DIGIT_W-1:0] xd, input logic [DIGIT_W-1:0] yd,
                           input logic last, input logic typed, input digits_t want);
    logic    emits;
    digits_t res;
    if (!calm && gap_pct != 0 && $urandom_range(1, 100) <= gap_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(negedge clk);
    end
    in_valid     <= 1'b1;
    in_x_digit   <= xd;
    in_y_digit   <= yd;
    in_last_term <= last;
    do @(posedge clk); while (in_stall);
    fold_pair(xd, yd, last, emits, res);
    if (emits) column_sums.push_back(typed ? want : res);
    @(negedge clk);
  endtask

  // Drop valid, wait out every owed sum, then give the pipeline time to
  // finish pairs that produce nothing.
  task automatic settle_block();
    in_valid <= 1'b0;
    while (hold_req || column_sums.size() != 0) @(negedge clk);
    settle = 1'b1;
    repeat (SETTLE_CYCLES) @(negedge clk);
    settle = 1'b0;
  endtask

  task automatic read_radix(input logic want_mode);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= RADIX_ADDR;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata[0] !== want_mode) begin
      $error("radix_mode readback: expected %0d, actual %0d", want_mode, prdata[0]);
      failures++;
    end
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic program_radix(input logic mode);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= RADIX_ADDR;
    pwdata  <= 32'(mode);
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    radix_q = mode;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk);
    read_radix(mode);
  endtask

  // Receiver: one long hold on request, otherwise random stall bursts
  initial begin
    int unsigned held;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        out_stall <= 1'b1;
        for (held = 0; held < HOLD_CYCLES; held++) @(negedge clk);
        out_stall <= 1'b0;
        hold_req = 1'b0;
      end else if (!calm && !settle && stall_pct != 0 &&
                   $urandom_range(1, 100) <= stall_pct) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 11)) @(negedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // Check each accepted result against the oldest owed column sum
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (column_sums.size() == 0) begin
        $error("unexpected item: low %0d mid %0d high %0d",
               out_low_digit, out_mid_digit, out_high_digit);
        failures++;
      end else begin
        seen_want = column_sums.pop_front();
        if (out_low_digit !== seen_want.low) begin
          $error("low_digit: expected %0d, actual %0d", seen_want.low, out_low_digit);
          failures++;
        end
        if (out_mid_digit !== seen_want.mid) begin
          $error("mid_digit: expected %0d, actual %0d", seen_want.mid, out_mid_digit);
          failures++;
        end
        if (out_high_digit !== seen_want.high) begin
          $error("high_digit: expected %0d, actual %0d", seen_want.high, out_high_digit);
          failures++;
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("FAILURE");
      $finish;
    end
  end

  initial begin
    plan_row_t   row;
    int unsigned r;
    int unsigned fed;
    int unsigned sums;
    int unsigned len;
    int unsigned kind;
    logic        next_mode;
    logic        open_sum;
    bit          held_once;

    fed = 0;
    held_once = 1'b0;

    // Hold reset, then release it at a falling edge
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    read_radix(RADIX_BIN);

    // Directed plan; a radix change waits for the block to go idle
    for (int i = 0; i < $size(DIRECTED); i++) begin
      row = DIRECTED[i];
      if (row.mode != radix_q) begin
        settle_block();
        program_radix(row.mode);
      end
      for (r = 0; r < row.reps; r++)
        send_pair(row.x, row.y, row.last && (r == row.reps - 1), row.typed, row.want);
    end

    // Random phases: each picks a radix and pacing, then streams a few sums.
    // A phase may end with an open sum so the next radix inherits it.
    while (fed < RANDOM_ITEMS) begin
      next_mode = logic'($urandom_range(0, 1));
      if (next_mode != radix_q) begin
        settle_block();
        program_radix(next_mode);
      end
      case ($urandom_range(0, 2))
        0: gap_pct = 0;
        1: gap_pct = 10;
        default: gap_pct = 30;
      endcase
      case ($urandom_range(0, 2))
        0: stall_pct = 0;
        1: stall_pct = 10;
        default: stall_pct = 30;
      endcase
      // Fill the queue once: the receiver holds while items keep coming
      if (!held_once) begin
        hold_req = 1'b1;
        held_once = 1'b1;
      end
      sums = $urandom_range(2, 6);
      for (int s = 0; s < sums; s++) begin
        kind = $urandom_range(0, 9);
        if (kind < 7) len = $urandom_range(1, 8);
        else if (kind == 7) len = $urandom_range(30, 70);
        else len = 1;
        open_sum = (s == sums - 1) && ($urandom_range(0, 3) == 0);
        for (int k = 0; k < len; k++)
          send_pair(pick_digit(kind == 7), pick_digit(kind == 7),
                    (k == len - 1) && !open_sum, 1'b0, NO_WANT);
        fed += len;
        calm = (fed + CALM_ITEMS >= RANDOM_ITEMS);
      end
    end

    // Drain and let the pipeline empty before judging
    in_valid <= 1'b0;
    while (column_sums.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
    if (failures == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
